### src/lqsr_pkg.sv
package lqsr_pkg;

  // payload widths fixed by the item format
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW  = 4;

  // default number of queue slots
  localparam int unsigned LqDepth = 8;

  // command codes
  localparam logic [CmdW-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CmdW-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CmdW-1:0] CMD_SRCH = 2'd2;
  localparam logic [CmdW-1:0] CMD_REPL = 2'd3;

  // status codes
  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatW-1:0] ST_NOTFOUND = 2'd3;

endpackage

### src/lqsr_if.sv
// request channel: command with key and replacement value
interface lqsr_in_if import lqsr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic signed [DataW-1:0] value;
  logic signed [DataW-1:0] new_value;

  modport source (output valid, command, value, new_value, input ready);
  modport sink   (input valid, command, value, new_value, output ready);
endinterface

// response channel: status, dequeued data and match position
interface lqsr_out_if import lqsr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] data_out;
  logic [PosW-1:0]         position;

  modport source (output valid, status, data_out, position, input ready);
  modport sink   (input valid, status, data_out, position, output ready);
endinterface

### src/lqsr_ram.sv
module lqsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/linear_queue_search_replace.sv
// Linear (non-circular) queue of Depth signed 32-bit slots held in a synchronous
// RAM with a registered read port, with front and rear indices in flip-flops. One
// command is handled at a time: enqueue writes its slot on acceptance and then
// presents its result, dequeue first does one RAM read, and search or replace
// scans, reading one slot per cycle from the front until the first match
// or the rear. Full is reported whenever the rear sits at the last slot, even
// after dequeues; dequeuing the last entry returns both indices to zero. A
// result waits in an output register, so a new command is taken while the
// previous result has not yet been picked up.
module linear_queue_search_replace import lqsr_pkg::*; #(
  parameter int unsigned Depth = LqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lqsr_in_if.sink     in_i,
  lqsr_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  front_q, front_d;
  logic [IdxW-1:0]  rear_q, rear_d;
  logic             empty_q, empty_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [DataW-1:0] key_q, key_d;
  logic [DataW-1:0] nval_q, nval_d;

  logic [StatW-1:0] res_status_q, res_status_d;
  logic [DataW-1:0] res_data_q, res_data_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;

  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] out_status_q, out_status_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic [PosW-1:0]  out_pos_q, out_pos_d;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic             in_fire, out_free, hit, scan_end;
  logic [IdxW+4:0]  hit_pos;

  // slot storage
  lqsr_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready     = (state_q == S_IDLE);
  assign in_fire        = in_i.valid && in_i.ready;
  assign out_free       = !out_valid_q || out_o.ready;
  assign hit            = (ram_rdata == key_q);
  assign scan_end       = (ptr_q == rear_q);
  assign hit_pos        = (IdxW+5)'(ptr_q) + (IdxW+5)'(1);

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.data_out = out_data_q;
  assign out_o.position = out_pos_q;

  // command sequencer and ram access
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    rear_d       = rear_q;
    empty_d      = empty_q;
    ptr_d        = ptr_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    nval_d       = nval_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = rear_q;
    ram_wdata    = DataW'(in_i.value);
    ram_re       = 1'b0;
    ram_raddr    = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d        = in_i.command;
          key_d        = DataW'(in_i.value);
          nval_d       = DataW'(in_i.new_value);
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_pos_d    = '0;
          ptr_d        = front_q;
          if (in_i.command == CMD_ENQ) begin
            state_d = S_RESP;
            if (!empty_q && rear_q == LastIdx) begin
              res_status_d = ST_FULL;
            end else if (empty_q) begin
              front_d   = '0;
              rear_d    = '0;
              empty_d   = 1'b0;
              ram_we    = 1'b1;
              ram_waddr = '0;
            end else begin
              rear_d    = rear_q + IdxW'(1);
              ram_we    = 1'b1;
              ram_waddr = rear_q + IdxW'(1);
            end
          end else if (empty_q) begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESP;
          end else begin
            ram_re  = 1'b1;
            state_d = (in_i.command == CMD_DEQ) ? S_DEQ : S_SCAN;
          end
        end
      end

      S_DEQ: begin
        res_data_d = ram_rdata;
        if (front_q == rear_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end else begin
          front_d = front_q + IdxW'(1);
        end
        state_d = S_RESP;
      end

      S_SCAN: begin
        if (hit) begin
          res_pos_d = hit_pos[PosW-1:0];
          state_d   = S_RESP;
          if (cmd_q == CMD_REPL) begin
            ram_we    = 1'b1;
            ram_waddr = ptr_q;
            ram_wdata = nval_q;
          end
        end else if (scan_end) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          ptr_d     = ptr_q + IdxW'(1);
          ram_re    = 1'b1;
          ram_raddr = ptr_q + IdxW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_pos_d    = out_pos_q;
    if (state_q == S_RESP && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_data_d   = res_data_q;
      out_pos_d    = res_pos_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    nval_q       <= nval_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_pos_q    <= out_pos_d;
  end

endmodule

### src/lqsr_chk.sv
module lqsr_chk import lqsr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [StatW-1:0] out_status_i,
  input logic [DataW-1:0] out_data_i,
  input logic [PosW-1:0]  out_pos_i
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_data_i) && $stable(out_pos_i))
    else $error("result changed while stalled");

  // one command in flight: no new transaction right after one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in progress");

  // dequeued data only comes with an ok status
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i != '0 |-> out_status_i == ST_OK && out_pos_i == '0)
    else $error("data on a failed or search transaction");

  // a match position only comes with an ok status
  a_pos_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pos_i != '0 |-> out_status_i == ST_OK)
    else $error("position on a failed transaction");

endmodule

bind linear_queue_search_replace lqsr_chk u_lqsr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_data_i   (out_o.data_out),
  .out_pos_i    (out_o.position)
);
